FILE: design/tfrpc_pkg.sv
// shared constants and types for the range packet classifier
`timescale 1ns / 1ps
package tfrpc_pkg;
   localparam int MAX_RULES_DEF = 64;
   localparam int NUM_FIELDS = 10;
   localparam int FIELD_W = 32;
   localparam logic [31:0] WILDCARD_HIGH = 32'hFFFF_FFFF;

   localparam logic [2:0] OP_CLASSIFY = 3'd0;
   localparam logic [2:0] OP_STAGE    = 3'd1;
   localparam logic [2:0] OP_INSERT   = 3'd2;
   localparam logic [2:0] OP_REMOVE   = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] bounds_type;

   // per-cycle command shared by all cells
   typedef struct packed {
      logic load;    // write staged rule at target
      logic shup;    // cells above target take left neighbor
      logic shdn;    // cells at or above target take right neighbor
   } cell_cmd_type;
endpackage

FILE: design/tfrpc_cell.sv
// one rule cell: holds ten ranges, shifts with its neighbors, matches a header
`timescale 1ns / 1ps
module tfrpc_cell (
   input  logic                  clock,
   input  tfrpc_pkg::cell_cmd_type cmd,
   input  logic                  at_target,
   input  logic                  above_target,
   input  tfrpc_pkg::bounds_type stage_low,
   input  tfrpc_pkg::bounds_type stage_high,
   input  tfrpc_pkg::bounds_type left_low,
   input  tfrpc_pkg::bounds_type left_high,
   input  tfrpc_pkg::bounds_type right_low,
   input  tfrpc_pkg::bounds_type right_high,
   input  tfrpc_pkg::bounds_type header,
   output tfrpc_pkg::bounds_type low_out,
   output tfrpc_pkg::bounds_type high_out,
   output logic                  hit
);
   import tfrpc_pkg::*;
   bounds_type low_ff, high_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && at_target) begin
         low_ff  <= stage_low;
         high_ff <= stage_high;
      end else if (cmd.shup && above_target) begin
         low_ff  <= left_low;
         high_ff <= left_high;
      end else if (cmd.shdn && (at_target || above_target)) begin
         low_ff  <= right_low;
         high_ff <= right_high;
      end
   end

   always_comb begin
      hit = 1'b1;
      for (int f = 0; f < NUM_FIELDS; f++) begin
         if (header[f] < low_ff[f] || header[f] > high_ff[f]) hit = 1'b0;
      end
   end

   assign low_out  = low_ff;
   assign high_out = high_ff;
endmodule

FILE: design/tfrpc_first_hit.sv
// registered priority search over the cell hit vector, cut in two levels
`timescale 1ns / 1ps
module tfrpc_first_hit #(
   parameter int MAX_RULES = tfrpc_pkg::MAX_RULES_DEF
) (
   input  logic                          clock,
   input  logic [MAX_RULES-1:0]          hits,
   output logic                          found,
   output logic [$clog2(MAX_RULES+1)-1:0] index
);
   localparam int IW = $clog2(MAX_RULES+1);
   localparam int GS = 16;
   localparam int NG = (MAX_RULES + GS - 1) / GS;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;
   logic [NG-1:0]                any_ff;
   logic [NG-1:0][3:0]           sub_ff;

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) begin
         any_ff[g] <= 1'b0;
         sub_ff[g] <= 4'd0;
         for (int b = GS - 1; b >= 0; b--) begin
            if (g * GS + b < MAX_RULES && hits[g * GS + b]) begin
               any_ff[g] <= 1'b1;
               sub_ff[g] <= 4'(b);
            end
         end
      end
   end

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            found = 1'b1;
            index = IW'({GW'(g), sub_ff[g]});
         end
      end
   end
endmodule

FILE: design/ten_field_range_packet_classifier_unit.sv
// top level of the ten-field range packet classifier
`timescale 1ns / 1ps
// Ten-field range classifier built as a row of rule cells.
// Request channel (req_*): operation, ten header fields, position.
//   classify: lowest rule whose ten inclusive ranges hold the header.
//   stage: position picks a field, field_0/field_1 give low/high bound.
//   insert/remove: staged rule enters at position, later cells shift up,
//   or the cell at position drops and later cells shift down. clear empties.
// Response channel (rsp_*): match_found, match_index, rule_count, status,
//   one response per request.
// After a request is taken its header is registered, the cells compare in parallel,
// a registered two-level priority search picks the first hit, and the response is
// registered. Insert/remove do their whole shift at once, each moving cell loading
// from its neighbor or, on insert, from staging. A new request is taken the cycle
// after the previous response is taken, so only one request is in flight at a time.
// A stalled response holds in its register and the request side stays stalled.
// Reset empties the table and sets staging to the wildcard range; rule cells
// need no clearing.
module ten_field_range_packet_classifier_unit #(
   parameter int MAX_RULES = tfrpc_pkg::MAX_RULES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_field_0, req_field_1, req_field_2, req_field_3, req_field_4,
   input  logic [31:0] req_field_5, req_field_6, req_field_7, req_field_8, req_field_9,
   input  logic [6:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_match_found,
   output logic [5:0]  rsp_match_index,
   output logic [6:0]  rsp_rule_count,
   output logic [1:0]  rsp_status
);
   import tfrpc_pkg::*;
   localparam int CW = $clog2(MAX_RULES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SRCH = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   bounds_type    stage_low_ff, stage_high_ff, header_ff;
   logic          classify_ff;
   logic [1:0]    status_ff;
   logic          found_ff;
   logic [5:0]    index_ff;
   cell_cmd_type  cmd;
   bounds_type    req_hdr;
   bounds_type    low_w [MAX_RULES];
   bounds_type    high_w [MAX_RULES];
   logic [MAX_RULES-1:0] hits;
   logic          fh_found;
   logic [CW-1:0] fh_index;
   logic          take;
   logic [31:0]   pos_ext, cnt_ext;

   assign req_hdr = {req_field_9, req_field_8, req_field_7, req_field_6, req_field_5,
                     req_field_4, req_field_3, req_field_2, req_field_1, req_field_0};
   assign req_stall = (state_ff != S_IDLE);
   assign take = req_valid && !req_stall;
   assign pos_ext = 32'(req_position);
   assign cnt_ext = 32'(count_ff);

   always_comb begin
      cmd = '0;
      if (take && req_operation == OP_INSERT && pos_ext <= cnt_ext
          && cnt_ext < MAX_RULES) begin
         cmd.load = 1'b1;
         cmd.shup = 1'b1;
      end
      if (take && req_operation == OP_REMOVE && pos_ext < cnt_ext) cmd.shdn = 1'b1;
   end

   genvar i;
   generate
      for (i = 0; i < MAX_RULES; i++) begin : g_cell
         logic at_t, above_t;
         logic hraw;
         assign at_t    = (32'(i) == pos_ext);
         assign above_t = (32'(i) > pos_ext);
         tfrpc_cell u_cell (
            .clock(clock), .cmd(cmd), .at_target(at_t), .above_target(above_t),
            .stage_low(stage_low_ff), .stage_high(stage_high_ff),
            .left_low(low_w[(i == 0) ? 0 : i - 1]),
            .left_high(high_w[(i == 0) ? 0 : i - 1]),
            .right_low(low_w[(i == MAX_RULES - 1) ? i : i + 1]),
            .right_high(high_w[(i == MAX_RULES - 1) ? i : i + 1]),
            .header(header_ff), .low_out(low_w[i]), .high_out(high_w[i]),
            .hit(hraw));
         assign hits[i] = hraw && (32'(i) < cnt_ext);
      end
   endgenerate

   tfrpc_first_hit #(.MAX_RULES(MAX_RULES)) u_first (
      .clock(clock), .hits(hits), .found(fh_found), .index(fh_index));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: if (take) begin
            state_in = S_SRCH;
            if (cmd.load) count_in = count_ff + 1'b1;
            if (cmd.shdn) count_in = count_ff - 1'b1;
            if (req_operation == OP_CLEAR) count_in = '0;
         end
         S_SRCH: state_in = S_PICK;
         S_PICK: state_in = S_RESP;
         S_RESP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         for (int f = 0; f < NUM_FIELDS; f++) begin
            stage_low_ff[f]  <= '0;
            stage_high_ff[f] <= WILDCARD_HIGH;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (take && req_operation == OP_STAGE && req_position < 7'(NUM_FIELDS)) begin
            stage_low_ff[req_position[3:0]]  <= req_field_0;
            stage_high_ff[req_position[3:0]] <= req_field_1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         header_ff   <= req_hdr;
         classify_ff <= (req_operation == OP_CLASSIFY);
         status_ff   <= ST_OK;
         case (req_operation)
            OP_STAGE:  if (req_position >= 7'(NUM_FIELDS)) status_ff <= ST_RANGE;
            OP_INSERT: begin
               if (pos_ext > cnt_ext) status_ff <= ST_RANGE;
               else if (cnt_ext >= MAX_RULES) status_ff <= ST_FULL;
            end
            OP_REMOVE: if (pos_ext >= cnt_ext) status_ff <= ST_RANGE;
            default: ;
         endcase
      end
      if (state_ff == S_PICK) begin
         found_ff <= classify_ff && fh_found;
         index_ff <= (classify_ff && fh_found) ? 6'(fh_index) : 6'd0;
      end
   end

   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_match_found = found_ff;
   assign rsp_match_index = index_ff;
   assign rsp_rule_count  = 7'(count_ff);
   assign rsp_status      = status_ff;
endmodule

FILE: tb/tb.sv
// self-checking testbench for the ten-field range packet classifier
`timescale 1ns / 1ps
module tb;
   import tfrpc_pkg::*;

   localparam int RULES = MAX_RULES_DEF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic       found;
      logic [5:0] index;
      logic [6:0] count;
      logic [1:0] status;
   } rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [31:0] req_field [NUM_FIELDS];
   logic [6:0]  req_position;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_match_found;
   logic [5:0]  rsp_match_index;
   logic [6:0]  rsp_rule_count;
   logic [1:0]  rsp_status;

   // classifier shadow state
   logic [31:0] tbl_low  [RULES][NUM_FIELDS];
   logic [31:0] tbl_high [RULES][NUM_FIELDS];
   int          tbl_count;
   logic [31:0] stg_low  [NUM_FIELDS];
   logic [31:0] stg_high [NUM_FIELDS];

   rsp_type     expected_rsp [$];
   int          errors;
   int          accepted;
   int          rsp_seen;
   int          idle_cycles;
   bit          hold_rsp;
   bit          bursty;

   ten_field_range_packet_classifier_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_field_0(req_field[0]), .req_field_1(req_field[1]), .req_field_2(req_field[2]),
      .req_field_3(req_field[3]), .req_field_4(req_field[4]), .req_field_5(req_field[5]),
      .req_field_6(req_field[6]), .req_field_7(req_field[7]), .req_field_8(req_field[8]),
      .req_field_9(req_field[9]), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_match_found(rsp_match_found), .rsp_match_index(rsp_match_index),
      .rsp_rule_count(rsp_rule_count), .rsp_status(rsp_status)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type classify_predict(logic [2:0] op, logic [31:0] hdr [NUM_FIELDS],
                                                logic [6:0] pos);
      rsp_type r;
      bit hit;
      r = '0;
      case (op)
         OP_CLASSIFY: begin
            for (int i = 0; i < tbl_count && !r.found; i++) begin
               hit = 1;
               for (int f = 0; f < NUM_FIELDS; f++)
                  if (hdr[f] < tbl_low[i][f] || hdr[f] > tbl_high[i][f]) hit = 0;
               if (hit) begin
                  r.found = 1;
                  r.index = i[5:0];
               end
            end
         end
         OP_STAGE: begin
            if (pos >= NUM_FIELDS) r.status = ST_RANGE;
            else begin
               stg_low[pos] = hdr[0];
               stg_high[pos] = hdr[1];
            end
         end
         OP_INSERT: begin
            if (pos > tbl_count) r.status = ST_RANGE;
            else if (tbl_count >= RULES) r.status = ST_FULL;
            else begin
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_low[i] = tbl_low[i-1];
                  tbl_high[i] = tbl_high[i-1];
               end
               tbl_low[pos] = stg_low;
               tbl_high[pos] = stg_high;
               tbl_count++;
            end
         end
         OP_REMOVE: begin
            if (pos >= tbl_count) r.status = ST_RANGE;
            else begin
               for (int i = pos; i < tbl_count - 1; i++) begin
                  tbl_low[i] = tbl_low[i+1];
                  tbl_high[i] = tbl_high[i+1];
               end
               tbl_count--;
            end
         end
         OP_CLEAR: tbl_count = 0;
         default: ;
      endcase
      r.count = tbl_count[6:0];
      return r;
   endfunction

   // one request, with a random gap in front of it when bursty
   task automatic send_request(logic [2:0] op, logic [31:0] hdr [NUM_FIELDS], logic [6:0] pos);
      if (bursty && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 6)) @(negedge clock);
      req_valid = 1;
      req_operation = op;
      req_field = hdr;
      req_position = pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp = {expected_rsp, classify_predict(op, hdr, pos)};
      accepted++;
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return WILDCARD_HIGH;
         2: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic stage_field(int f, logic [31:0] lo, logic [31:0] hi);
      logic [31:0] h [NUM_FIELDS];
      foreach (h[i]) h[i] = $urandom;
      h[0] = lo;
      h[1] = hi;
      send_request(OP_STAGE, h, f[6:0]);
   endtask

   task automatic send_simple(logic [2:0] op, logic [6:0] pos);
      logic [31:0] h [NUM_FIELDS];
      foreach (h[i]) h[i] = $urandom;
      send_request(op, h, pos);
   endtask

   task automatic send_header(logic [31:0] v);
      logic [31:0] h [NUM_FIELDS];
      foreach (h[i]) h[i] = v;
      send_request(OP_CLASSIFY, h, 7'($urandom));
   endtask

   task automatic drain();
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_header(32'h0);                      // empty table
      stage_field(12, 32'h1, 32'h2);           // bad field number
      send_simple(OP_INSERT, 7'd1);            // insert past end
      send_simple(OP_REMOVE, 7'd0);            // remove from empty
      send_simple(OP_INSERT, 7'd0);            // wildcard rule
      send_header(WILDCARD_HIGH);
      stage_field(0, 32'h10, 32'h20);
      stage_field(9, 32'h30, 32'h5);           // inverted range never matches
      send_simple(OP_INSERT, 7'd0);
      send_simple(OP_INSERT, 7'd0);            // staging kept after insert
      send_header(32'h15);
      send_simple(OP_REMOVE, 7'd2);
      send_simple(OP_REMOVE, 7'd1);
      send_header(32'h15);
      send_simple(3'd5, 7'd0);
      send_simple(3'd7, 7'd127);
      send_simple(OP_CLEAR, 7'd0);
      send_header(32'h15);
      drain();
   endtask

   task automatic test_fill_table();
      for (int i = 0; i < NUM_FIELDS; i++) stage_field(i, 32'h0, WILDCARD_HIGH);
      stage_field(3, 32'h100, 32'h1FF);
      for (int i = 0; i <= RULES; i++) send_simple(OP_INSERT, 7'($urandom_range(0, i)));
      send_simple(OP_INSERT, 7'd70);           // range error beats full
      send_header(32'h150);
      send_simple(OP_REMOVE, 7'd63);
      send_simple(OP_REMOVE, 7'd64);
      drain();
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      hold_rsp = 1;
      fork
         begin
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 20; i++) send_header($urandom);
      join
      drain();
   endtask

   task automatic test_random(int n);
      int f;
      logic [31:0] a, b;
      logic [31:0] h [NUM_FIELDS];
      bursty = 1;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               f = $urandom_range(0, 10) == 0 ? $urandom_range(10, 127) : $urandom_range(0, 9);
               a = pick_value();
               b = $urandom_range(0, 2) == 0 ? WILDCARD_HIGH : a + $urandom_range(0, 64);
               if ($urandom_range(0, 15) == 0) b = pick_value();
               stage_field(f, a, b);
            end
            4, 5, 6:
               send_simple(OP_INSERT, 7'($urandom_range(0, tbl_count + 1)));
            7, 8:
               send_simple(OP_REMOVE, 7'($urandom_range(0, tbl_count)));
            9:
               if ($urandom_range(0, 9) == 0) send_simple(OP_CLEAR, 7'($urandom));
               else send_simple(3'($urandom_range(5, 7)), 7'($urandom));
            default: begin
               // usually aim inside a stored rule so matches are common
               if (tbl_count != 0 && $urandom_range(0, 3) != 0) begin
                  f = $urandom_range(0, tbl_count - 1);
                  foreach (h[i]) begin
                     a = tbl_low[f][i];
                     b = tbl_high[f][i];
                     h[i] = (a <= b) ? a + 32'($urandom_range(0, 3)) : a;
                     if (h[i] > b) h[i] = b;
                  end
               end else foreach (h[i]) h[i] = pick_value();
               send_request(OP_CLASSIFY, h, 7'($urandom));
            end
         endcase
      end
      drain();
      bursty = 0;
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_rsp) rsp_stall <= 1;
      else if (!bursty) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // response checker
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response found=%0d index=%0d count=%0d status=%0d",
                     $time, rsp_match_found, rsp_match_index, rsp_rule_count, rsp_status);
         end else begin
            exp_r = expected_rsp.pop_front();
            if (rsp_match_found !== exp_r.found) begin
               errors++;
               $display("%0t: match_found expected %0d got %0d", $time, exp_r.found,
                        rsp_match_found);
            end
            if (rsp_match_index !== exp_r.index) begin
               errors++;
               $display("%0t: match_index expected %0d got %0d", $time, exp_r.index,
                        rsp_match_index);
            end
            if (rsp_rule_count !== exp_r.count) begin
               errors++;
               $display("%0t: rule_count expected %0d got %0d", $time, exp_r.count,
                        rsp_rule_count);
            end
            if (rsp_status !== exp_r.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $time, exp_r.status, rsp_status);
            end
         end
      end
   end

   // watchdog on handshake inactivity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      errors = 0;
      accepted = 0;
      rsp_seen = 0;
      hold_rsp = 0;
      bursty = 0;
      tbl_count = 0;
      foreach (stg_low[i]) begin
         stg_low[i] = '0;
         stg_high[i] = WILDCARD_HIGH;
      end
      reset = 1;
      rsp_stall = 0;
      req_valid = 0;
      req_operation = OP_CLASSIFY;
      req_position = '0;
      foreach (req_field[i]) req_field[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_fill_table();
      test_backpressure();
      test_random(1032);
      repeat (20) @(negedge clock);
      $display("covered %0d requests and %0d responses: all operations, errors, full table,",
               accepted, rsp_seen);
      $display("shifting insert/remove, inverted and wildcard ranges, stalls and hold-off");
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
